// File: src/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared widths and defaults for the strong probable prime tester.
// ----------------------------------------------------------------------------
`default_nettype none
package mrpt_pkg;
  localparam int FIELD_BITS       = 63;
  localparam int NUMBER_BITS_DEF  = 63;
endpackage
`default_nettype wire

// File: src/mrpt_if.sv
// ----------------------------------------------------------------------------
// mrpt_if
// Valid/ready channels: candidate and base in, verdict out.
// ----------------------------------------------------------------------------
`default_nettype none
interface mrpt_in_if import mrpt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] candidate;
  logic [FIELD_BITS-1:0] base;
  modport source (output valid, candidate, base, input ready);
  modport sink   (input valid, candidate, base, output ready);
endinterface

interface mrpt_out_if ();
  logic valid;
  logic ready;
  logic probable_prime;
  modport source (output valid, probable_prime, input ready);
  modport sink   (input valid, probable_prime, output ready);
endinterface
`default_nettype wire

// File: src/mrpt_mulmod.sv
// ----------------------------------------------------------------------------
// mrpt_mulmod
// Bit-serial (a * b) mod m, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mrpt_mulmod import mrpt_pkg::*; #(
  parameter int W = NUMBER_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic [W-1:0] m,
  output logic              done,
  output logic [W-1:0]      prod
);
  localparam int CW = $clog2(W);

  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  x_r, x_nxt, y_r, y_nxt, acc_r, acc_nxt, m_r, m_nxt;
  logic [W:0]    sum, dbl;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    m_nxt    = m_r;
    sum      = {1'b0, acc_r} + {1'b0, x_r};
    dbl      = {x_r, 1'b0};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = a;
      y_nxt    = b;
      acc_nxt  = '0;
      m_nxt    = m;
    end else if (busy_r) begin
      if (y_r[0]) begin
        acc_nxt = (sum >= {1'b0, m_r}) ? W'(sum - {1'b0, m_r}) : sum[W-1:0];
      end
      x_nxt = (dbl >= {1'b0, m_r}) ? W'(dbl - {1'b0, m_r}) : dbl[W-1:0];
      y_nxt = y_r >> 1;
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    m_r   <= m_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

// File: src/miller_rabin_prime_test.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_test
// Strong probable prime test of one candidate against one base.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_chan   in   valid/ready    candidate[62:0], base[62:0]
//  out_chan  out  valid/ready    probable_prime
//
//  An odd candidate runs the exponentiation and the squaring loop on the
//  bit-serial modular multiplier, at most 2*W - 1 products in all
//  (W = NUMBER_BITS). Trivial candidates go straight to the output stage.
//  Reset is synchronous, active low.
//  A new item is taken while a verdict still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module miller_rabin_prime_test import mrpt_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mrpt_in_if.sink     in_chan,
  mrpt_out_if.source  out_chan
);
  localparam int W  = NUMBER_BITS;
  localparam int IW = $clog2(W);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MOD  = 4'd1;
  localparam logic [3:0] S_GCD  = 4'd2;
  localparam logic [3:0] S_SPLT = 4'd3;
  localparam logic [3:0] S_PSQ  = 4'd4;
  localparam logic [3:0] S_PMUL = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_SQL  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [W-1:0]  n_r, n_nxt, b_r, b_nxt, rem_r, rem_nxt, u_r, u_nxt, v_r, v_nxt;
  logic [W-1:0]  q_r, q_nxt, acc_r, acc_nxt;
  logic [IW-1:0] p_r, p_nxt, k_r, k_nxt;
  logic          res_r, res_nxt, launched_r, launched_nxt;
  logic          ov_r, ov_nxt, opp_r, opp_nxt;

  logic [W-1:0]  cw, bw, nm1, rstep;
  logic [W:0]    rem2;
  logic          mm_start, mm_done;
  logic [W-1:0]  mm_b, mm_prod;

  mrpt_mulmod #(.W(W)) u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .a     (acc_r),
    .b     (mm_b),
    .m     (n_r),
    .done  (mm_done),
    .prod  (mm_prod)
  );

  assign mm_b       = (state_r == S_PMUL) ? b_r : acc_r;
  assign cw         = in_chan.candidate[W-1:0];
  assign bw         = in_chan.base[W-1:0];
  assign nm1        = n_r - W'(1);
  assign rem2       = {rem_r, b_r[k_r]};
  assign rstep      = (rem2 >= {1'b0, n_r}) ? W'(rem2 - {1'b0, n_r}) : rem2[W-1:0];
  assign in_chan.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    n_nxt        = n_r;
    b_nxt        = b_r;
    rem_nxt      = rem_r;
    u_nxt        = u_r;
    v_nxt        = v_r;
    q_nxt        = q_r;
    acc_nxt      = acc_r;
    p_nxt        = p_r;
    k_nxt        = k_r;
    res_nxt      = res_r;
    launched_nxt = launched_r;
    mm_start     = 1'b0;
    ov_nxt       = ov_r;
    opp_nxt      = opp_r;
    if (ov_r && out_chan.ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          n_nxt   = cw;
          b_nxt   = (bw < W'(2)) ? W'(2) : bw;
          rem_nxt = '0;
          k_nxt   = IW'(W - 1);
          if (cw == W'(2)) begin
            res_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else if (cw < W'(2) || !cw[0]) begin
            res_nxt   = 1'b0;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        rem_nxt = rstep;
        k_nxt   = k_r - IW'(1);
        if (k_r == '0) begin
          u_nxt     = n_r;
          v_nxt     = (rstep == '0) ? W'(1) : rstep;
          b_nxt     = (rstep == '0) ? W'(1) : rstep;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (v_r == '0) begin
          if (u_r == W'(1)) begin
            q_nxt     = nm1;
            p_nxt     = '0;
            state_nxt = S_SPLT;
          end else begin
            res_nxt   = 1'b0;
            state_nxt = S_FIN;
          end
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (v_r >= u_r) begin
          v_nxt = v_r - u_r;
        end else begin
          u_nxt = v_r;
          v_nxt = u_r - v_r;
        end
      end
      S_SPLT: begin
        if (!q_r[0]) begin
          q_nxt = q_r >> 1;
          p_nxt = p_r + IW'(1);
        end else begin
          acc_nxt   = W'(1);
          k_nxt     = IW'(W - 1);
          state_nxt = S_PSQ;
        end
      end
      S_PSQ, S_PMUL, S_SQL: begin
        if (!launched_r) begin
          mm_start     = 1'b1;
          launched_nxt = 1'b1;
        end else if (mm_done) begin
          launched_nxt = 1'b0;
          acc_nxt      = mm_prod;
          if (state_r == S_SQL) begin
            if (mm_prod == nm1) begin
              res_nxt   = 1'b1;
              state_nxt = S_FIN;
            end else if (k_r == IW'(1)) begin
              res_nxt   = 1'b0;
              state_nxt = S_FIN;
            end else begin
              k_nxt = k_r - IW'(1);
            end
          end else if (state_r == S_PSQ && q_r[k_r]) begin
            state_nxt = S_PMUL;
          end else if (k_r == '0) begin
            state_nxt = S_CHK;
          end else begin
            k_nxt     = k_r - IW'(1);
            state_nxt = S_PSQ;
          end
        end
      end
      S_CHK: begin
        if (acc_r == W'(1) || acc_r == nm1) begin
          res_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (p_r <= IW'(1)) begin
          res_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else begin
          k_nxt     = p_r - IW'(1);
          state_nxt = S_SQL;
        end
      end
      S_FIN: begin
        if (!ov_r || out_chan.ready) begin
          ov_nxt    = 1'b1;
          opp_nxt   = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      launched_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      launched_r <= launched_nxt;
      ov_r       <= ov_nxt;
    end
    n_r   <= n_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    q_r   <= q_nxt;
    acc_r <= acc_nxt;
    p_r   <= p_nxt;
    k_r   <= k_nxt;
    res_r <= res_nxt;
    opp_r <= opp_nxt;
  end

  assign out_chan.valid          = ov_r;
  assign out_chan.probable_prime = opp_r;

  a_done_launched: assert property (@(posedge clk) disable iff (!rst_n)
    mm_done |-> launched_r)
    else $error("multiplier finished without a launch");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !launched_r)
    else $error("multiplier busy while idle");

  a_fin_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && (!ov_r || out_chan.ready)) |=> (ov_r && opp_r == $past(res_r)))
    else $error("verdict not transferred to output register");
endmodule
`default_nettype wire
